@@ sv/frm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frm_pkg
// Types and constants shared by the framed packet receiver.
// ----------------------------------------------------------------------------
package frm_pkg;

    localparam int DEF_MAX_FRAME_BYTES = 256;

    localparam logic [7:0] HEADER_RESET  = 8'hFE;
    localparam logic [7:0] END_RESET     = 8'hFA;
    localparam logic [7:0] MIN_LEN_RESET = 8'd5;
    localparam logic [7:0] LEN_FLOOR     = 8'd5;
    localparam logic [8:0] LEN_OVERHEAD  = 9'd3;
    localparam logic [8:0] WPOS_LIMIT    = 9'd511;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_END     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LEN = 2'd2;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_LENGTH  = 2'd1;
    localparam logic [1:0] ERR_END_BAD = 2'd2;

    typedef enum logic [3:0] {
        PH_HEAD1   = 4'd0,
        PH_HEAD2   = 4'd1,
        PH_LEN     = 4'd2,
        PH_ID      = 4'd3,
        PH_CMD     = 4'd4,
        PH_CONTENT = 4'd5,
        PH_CRCH    = 4'd6,
        PH_CRCL    = 4'd7,
        PH_END     = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        RD_NONE = 2'd0,
        RD_RAM  = 2'd1,
        RD_HEAD = 2'd2
    } rd_src_t;

endpackage
`default_nettype wire

@@ sv/frm_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frm_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module frm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ sv/framed_packet_receiver.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// framed_packet_receiver
// Parses a byte stream into framed packets and holds the last good frame
// for reading by index.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | dir
//  ---------+-------------------------------------------+-----
//  input    | in_valid/in_ready, command, rx_byte,      | in
//           | read_index                                |
//  result   | out_valid/out_ready, frame_done,          | out
//           | frame_ready, frame_length, error_code,    |
//           | parser_phase, read_data                   |
//  config   | cfg_we, cfg_index, cfg_data               | in
//
// one request per cycle while the result register can take it; each result
// shows in the next cycle, read data from the single registered store port
// the result register parts the two sides: a new request is taken whenever
// the result register is empty or being taken in the same cycle
// reset returns the parser to the first header phase with no frame held;
// frame store contents are not cleared
// ----------------------------------------------------------------------------
module framed_packet_receiver
    import frm_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   command,
    input  wire logic [7:0]             rx_byte,
    input  wire logic [7:0]             read_index,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        frame_done,
    output logic                        frame_ready,
    output logic [8:0]                  frame_length,
    output logic [1:0]                  error_code,
    output logic [3:0]                  parser_phase,
    output logic [7:0]                  read_data,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]             cfg_data
);

    localparam int ADDR_W = $clog2(MAX_FRAME_BYTES);
    localparam logic [8:0] STORE_SIZE = 9'(MAX_FRAME_BYTES);

    // configuration
    logic [7:0] header_byte_reg;
    logic [7:0] end_byte_reg;
    logic [7:0] min_length_reg;

    // parser state
    phase_t     phase_reg, phase_next;
    logic [8:0] write_pos_reg, write_pos_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] prev_byte_reg;
    logic       ready_reg, ready_next;
    logic [8:0] held_len_reg, held_len_next;
    logic [7:0] head0_reg, head1_reg;

    // result register
    logic       out_valid_reg;
    logic       done_reg, done_next;
    logic       rdy_out_reg;
    logic [8:0] len_out_reg;
    logic [1:0] err_reg, err_next;
    phase_t     phase_out_reg;
    rd_src_t    rd_src_reg, rd_src_next;
    logic [7:0] rd_head_reg;

    // store access
    logic              put;
    logic              head_both;
    logic              ram_we;
    logic              ram_re;
    logic [7:0]        ram_q;
    logic [ADDR_W-1:0] ram_waddr;
    logic [8:0]        put_pos;

    logic       accept;
    logic       take_byte;
    logic       dbl_head;
    logic       is_head;
    logic       len_ok;
    logic [7:0] len_floor;
    logic [8:0] wpos_inc;
    logic [8:0] wpos_adv;
    logic       wpos_in_store;
    logic       rd_in_store;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign take_byte = accept && !command;

    assign is_head       = rx_byte == header_byte_reg;
    assign dbl_head      = (prev_byte_reg == header_byte_reg) && is_head;
    assign len_floor     = (min_length_reg < LEN_FLOOR) ? LEN_FLOOR : min_length_reg;
    assign len_ok        = (rx_byte >= len_floor)
                        && (({1'b0, rx_byte} + LEN_OVERHEAD) <= STORE_SIZE);
    assign wpos_inc      = write_pos_reg + 9'd1;
    assign wpos_adv      = (write_pos_reg < WPOS_LIMIT) ? wpos_inc : write_pos_reg;
    assign wpos_in_store = write_pos_reg < STORE_SIZE;
    assign rd_in_store   = {1'b0, read_index} < STORE_SIZE;

    // first header always lands at the start of the store
    assign put_pos = (phase_reg == PH_HEAD1) ? 9'd0 : write_pos_reg;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (dbl_head)
        begin
            phase_next = PH_LEN;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEAD1:   phase_next = is_head ? PH_HEAD2 : PH_HEAD1;
                PH_HEAD2:   phase_next = is_head ? PH_LEN : PH_HEAD1;
                PH_LEN:     phase_next = len_ok ? PH_ID : PH_HEAD1;
                PH_ID:      phase_next = PH_CMD;
                PH_CMD:     phase_next = (length_reg > LEN_FLOOR) ? PH_CONTENT : PH_CRCH;
                PH_CONTENT:
                begin
                    if (!wpos_in_store)
                    begin
                        phase_next = PH_HEAD1;
                    end
                    else if (wpos_inc >= {1'b0, length_reg})
                    begin
                        phase_next = PH_CRCH;
                    end
                end
                PH_CRCH:    phase_next = PH_CRCL;
                PH_CRCL:    phase_next = PH_END;
                PH_END:     phase_next = PH_HEAD1;
                default:    phase_next = PH_HEAD1;
            endcase
        end
    end

    // parser outputs and datapath updates
    always_comb
    begin
        put            = 1'b0;
        head_both      = 1'b0;
        write_pos_next = write_pos_reg;
        length_next    = length_reg;
        ready_next     = ready_reg;
        held_len_next  = held_len_reg;
        done_next      = 1'b0;
        err_next       = ERR_NONE;
        if (dbl_head)
        begin
            head_both      = 1'b1;
            write_pos_next = 9'd2;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEAD1:
                begin
                    if (is_head)
                    begin
                        head_both      = 1'b0;
                        put            = 1'b1;
                        write_pos_next = 9'd1;
                    end
                end
                PH_HEAD2:
                begin
                    if (is_head)
                    begin
                        put            = 1'b1;
                        write_pos_next = wpos_adv;
                    end
                    else
                    begin
                        write_pos_next = '0;
                    end
                end
                PH_LEN:
                begin
                    put = 1'b1;
                    if (len_ok)
                    begin
                        length_next    = rx_byte;
                        write_pos_next = wpos_adv;
                    end
                    else
                    begin
                        length_next    = '0;
                        write_pos_next = '0;
                        ready_next     = 1'b0;
                        err_next       = ERR_LENGTH;
                    end
                end
                PH_CONTENT:
                begin
                    if (wpos_in_store)
                    begin
                        put            = 1'b1;
                        write_pos_next = wpos_adv;
                    end
                    else
                    begin
                        length_next    = '0;
                        write_pos_next = '0;
                        ready_next     = 1'b0;
                        err_next       = ERR_LENGTH;
                    end
                end
                PH_ID, PH_CMD, PH_CRCH, PH_CRCL:
                begin
                    put            = 1'b1;
                    write_pos_next = wpos_adv;
                end
                PH_END:
                begin
                    if (rx_byte == end_byte_reg)
                    begin
                        put            = 1'b1;
                        write_pos_next = wpos_adv;
                        ready_next     = 1'b1;
                        held_len_next  = {1'b0, length_reg} + LEN_OVERHEAD;
                        done_next      = 1'b1;
                    end
                    else
                    begin
                        err_next = ERR_END_BAD;
                    end
                end
                default:
                begin
                    put = 1'b0;
                end
            endcase
        end
    end

    // head bytes live in registers, the rest in the store
    assign ram_we    = take_byte && put && (put_pos < STORE_SIZE) && (put_pos >= 9'd2);
    assign ram_waddr = put_pos[ADDR_W-1:0];
    assign ram_re    = accept && command && rd_in_store && (read_index >= 8'd2);

    always_comb
    begin
        priority if (!command || !rd_in_store)
        begin
            rd_src_next = RD_NONE;
        end
        else if (read_index >= 8'd2)
        begin
            rd_src_next = RD_RAM;
        end
        else
        begin
            rd_src_next = RD_HEAD;
        end
    end

    frm_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (read_index[ADDR_W-1:0]),
        .rdata (ram_q)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_byte_reg <= HEADER_RESET;
            end_byte_reg    <= END_RESET;
            min_length_reg  <= MIN_LEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEADER:  header_byte_reg <= cfg_data;
                CFG_END:     end_byte_reg    <= cfg_data;
                CFG_MIN_LEN: min_length_reg  <= cfg_data;
                default:     min_length_reg  <= min_length_reg;
            endcase
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEAD1;
            write_pos_reg <= '0;
            length_reg    <= '0;
            prev_byte_reg <= '0;
            ready_reg     <= 1'b0;
            held_len_reg  <= '0;
        end
        else if (take_byte)
        begin
            phase_reg     <= phase_next;
            write_pos_reg <= write_pos_next;
            length_reg    <= length_next;
            prev_byte_reg <= rx_byte;
            ready_reg     <= ready_next;
            held_len_reg  <= held_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_byte && (head_both || (put && (put_pos == 9'd0))))
        begin
            head0_reg <= rx_byte;
        end
        if (take_byte && (head_both || (put && (put_pos == 9'd1))))
        begin
            head1_reg <= rx_byte;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            done_reg      <= take_byte && done_next;
            err_reg       <= command ? ERR_NONE : err_next;
            phase_out_reg <= command ? phase_reg : phase_next;
            rdy_out_reg   <= command ? ready_reg : ready_next;
            if (command)
            begin
                len_out_reg <= ready_reg ? held_len_reg : 9'd0;
            end
            else
            begin
                len_out_reg <= ready_next ? held_len_next : 9'd0;
            end
            rd_src_reg  <= rd_src_next;
            rd_head_reg <= read_index[0] ? head1_reg : head0_reg;
        end
    end

    always_comb
    begin
        unique case (rd_src_reg)
            RD_RAM:  read_data = ram_q;
            RD_HEAD: read_data = rd_head_reg;
            default: read_data = 8'd0;
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign frame_done   = done_reg;
    assign frame_ready  = rdy_out_reg;
    assign frame_length = len_out_reg;
    assign error_code   = err_reg;
    assign parser_phase = phase_out_reg;

    // checks
    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> frame_ready && (error_code == ERR_NONE)
                                    && (parser_phase == PH_HEAD1))
        else $error("completed frame without ready flag or with error");

    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_ready |-> frame_length == 9'd0)
        else $error("frame length shown with no frame held");

    a_read_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command |=> !frame_done && (error_code == ERR_NONE))
        else $error("read request reported frame event");

    a_read_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command |=> $stable(phase_reg) && $stable(write_pos_reg))
        else $error("read request changed parser state");

endmodule
`default_nettype wire

@@ test/framed_packet_receiver_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_receiver_tb
// Self-checking bench for the frame parser. Byte and read requests go in over
// valid/ready while the bench keeps its own copy of the parser phase, the
// frame store and the held frame, and checks every result field in order.
// Covers minimal, full-store, rejected, truncated and badly terminated frames
// under several header/end/min-length settings, random idling on both sides
// and a long receiver hold-off.
// ----------------------------------------------------------------------------
module framed_packet_receiver_tb
    import frm_pkg::*;
();

    localparam int   STORE_BYTES = DEF_MAX_FRAME_BYTES;
    localparam int   STALL_LIMIT = 2000;
    localparam int   PRINT_LIMIT = 20;
    localparam logic CMD_RX      = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    typedef struct {
        logic       done;
        logic       ready;
        logic [8:0] length;
        logic [1:0] err;
        phase_t     phase;
        logic [7:0] rdata;
    } parser_status_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   command;
    logic [7:0]             rx_byte;
    logic [7:0]             read_index;
    logic                   out_valid;
    logic                   out_ready;
    logic                   frame_done;
    logic                   frame_ready;
    logic [8:0]             frame_length;
    logic [1:0]             error_code;
    logic [3:0]             parser_phase;
    logic [7:0]             read_data;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]             cfg_data;

    // tracked parser state
    logic [7:0] cfg_header;
    logic [7:0] cfg_end;
    logic [7:0] cfg_min_len;
    phase_t     rx_phase;
    logic [7:0] store_mem [STORE_BYTES];
    int         hi_written;
    logic [8:0] wr_ptr;
    logic [7:0] len_byte;
    logic [7:0] last_rx;
    logic       held_valid;
    logic [8:0] held_len;

    parser_status_t parser_status_q [$];

    int err_count;
    int req_count;
    int frames_done;
    int len_drops;
    int end_drops;
    int reads_done;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int quiet_cycles;

    framed_packet_receiver DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .rx_byte      (rx_byte),
        .read_index   (read_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_done   (frame_done),
        .frame_ready  (frame_ready),
        .frame_length (frame_length),
        .error_code   (error_code),
        .parser_phase (parser_phase),
        .read_data    (read_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void store_put(input logic [7:0] b);
        if (wr_ptr < STORE_BYTES)
        begin
            store_mem[wr_ptr[7:0]] = b;
            if (int'(wr_ptr) > hi_written)
                hi_written = int'(wr_ptr);
        end
        if (wr_ptr < WPOS_LIMIT)
            wr_ptr = wr_ptr + 9'd1;
    endfunction

    function automatic void drop_frame();
        rx_phase   = PH_HEAD1;
        wr_ptr     = '0;
        len_byte   = '0;
        held_valid = 1'b0;
    endfunction

    function automatic parser_status_t advance_parser(input logic cmd, input logic [7:0] b,
                                                      input logic [7:0] idx);
        parser_status_t s;
        logic [7:0]     lo;
        s.done  = 1'b0;
        s.err   = ERR_NONE;
        s.rdata = '0;
        lo = (cfg_min_len < LEN_FLOOR) ? LEN_FLOOR : cfg_min_len;
        if (cmd == CMD_READ)
        begin
            if (int'(idx) < STORE_BYTES)
                s.rdata = store_mem[idx];
            reads_done++;
        end
        else if (last_rx == cfg_header && b == cfg_header)
        begin
            // two headers in a row restart from any phase
            wr_ptr = '0;
            store_put(cfg_header);
            store_put(cfg_header);
            rx_phase = PH_LEN;
        end
        else
        begin
            case (rx_phase)
                PH_HEAD1:
                begin
                    if (b == cfg_header)
                    begin
                        wr_ptr = '0;
                        store_put(b);
                        rx_phase = PH_HEAD2;
                    end
                end
                PH_HEAD2:
                begin
                    if (b == cfg_header)
                    begin
                        store_put(b);
                        rx_phase = PH_LEN;
                    end
                    else
                    begin
                        rx_phase = PH_HEAD1;
                        wr_ptr   = '0;
                    end
                end
                PH_LEN:
                begin
                    len_byte = b;
                    store_put(b);
                    if (b >= lo && int'(b) + int'(LEN_OVERHEAD) <= STORE_BYTES)
                        rx_phase = PH_ID;
                    else
                    begin
                        drop_frame();
                        s.err = ERR_LENGTH;
                        len_drops++;
                    end
                end
                PH_ID:
                begin
                    store_put(b);
                    rx_phase = PH_CMD;
                end
                PH_CMD:
                begin
                    store_put(b);
                    rx_phase = (len_byte > LEN_FLOOR) ? PH_CONTENT : PH_CRCH;
                end
                PH_CONTENT:
                begin
                    if (wr_ptr < STORE_BYTES)
                    begin
                        store_put(b);
                        if (wr_ptr >= len_byte)
                            rx_phase = PH_CRCH;
                    end
                    else
                    begin
                        drop_frame();
                        s.err = ERR_LENGTH;
                        len_drops++;
                    end
                end
                PH_CRCH:
                begin
                    store_put(b);
                    rx_phase = PH_CRCL;
                end
                PH_CRCL:
                begin
                    store_put(b);
                    rx_phase = PH_END;
                end
                default:
                begin
                    if (b == cfg_end)
                    begin
                        store_put(b);
                        held_valid = 1'b1;
                        held_len   = LEN_OVERHEAD + 9'(len_byte);
                        s.done     = 1'b1;
                        frames_done++;
                    end
                    else
                    begin
                        s.err = ERR_END_BAD;
                        end_drops++;
                    end
                    rx_phase = PH_HEAD1;
                end
            endcase
        end
        if (cmd == CMD_RX)
            last_rx = b;
        s.ready  = held_valid;
        s.length = held_valid ? held_len : 9'd0;
        s.phase  = rx_phase;
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [8:0] got,
                                   input logic [8:0] want);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("mismatch on %s: got %0d, want %0d (t=%0t)", what, got, want, $time);
    endtask

    // one request per call; valid stays up across back-to-back requests
    task automatic send_req(input logic cmd, input logic [7:0] b, input logic [7:0] idx);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        rx_byte    <= b;
        read_index <= idx;
        do @(posedge clk); while (in_ready !== 1'b1);
        parser_status_q.push_back(advance_parser(cmd, b, idx));
        req_count++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_req(CMD_RX, b, 8'($urandom_range(255)));
    endtask

    task automatic send_read(input logic [7:0] idx);
        send_req(CMD_READ, 8'($urandom_range(255)), idx);
    endtask

    // reads stay inside the part of the store written so far
    task automatic random_read();
        if (hi_written >= 0)
            send_read(8'($urandom_range(hi_written, 0)));
    endtask

    function automatic logic [7:0] frame_fill();
        logic [7:0] v;
        v = 8'($urandom_range(255));
        if (v == cfg_header)
            v = ~v;
        return v;
    endfunction

    task automatic send_frame(input int len, input bit bad_end, input int keep);
        logic [7:0] fb [$];
        int         i;
        fb.push_back(cfg_header);
        fb.push_back(cfg_header);
        fb.push_back(8'(len));
        fb.push_back(frame_fill());
        fb.push_back(frame_fill());
        for (i = 5; i < len; i++)
            fb.push_back(frame_fill());
        fb.push_back(frame_fill());
        fb.push_back(frame_fill());
        fb.push_back(bad_end ? cfg_end ^ 8'($urandom_range(255, 1)) : cfg_end);
        for (i = 0; i < fb.size() && i < keep; i++)
        begin
            if ($urandom_range(9) == 0)
                random_read();
            send_byte(fb[i]);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (parser_status_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic load_config(input logic [7:0] hdr, input logic [7:0] endb,
                               input logic [7:0] minl);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HEADER;
        cfg_data  <= hdr;
        @(posedge clk);
        cfg_header = hdr;
        cfg_index <= CFG_END;
        cfg_data  <= endb;
        @(posedge clk);
        cfg_end = endb;
        cfg_index <= CFG_MIN_LEN;
        cfg_data  <= minl;
        @(posedge clk);
        cfg_min_len = minl;
        cfg_we <= 1'b0;
    endtask

    task automatic random_sequence();
        int r;
        int lo;
        int len;
        int top;
        lo  = (cfg_min_len < LEN_FLOOR) ? int'(LEN_FLOOR) : int'(cfg_min_len);
        top = (lo + 12 > 253) ? 253 : lo + 12;
        r   = $urandom_range(99);
        if (r < 72)
        begin
            if ($urandom_range(39) == 0)
                len = $urandom_range(253, lo);
            else
                len = $urandom_range(top, lo);
            send_frame(len, $urandom_range(9) == 0, 300);
        end
        else if (r < 80)
        begin
            if ($urandom_range(1) == 0)
                len = $urandom_range(lo - 1, 0);
            else
                len = $urandom_range(255, 254);
            send_frame(len, 1'b0, 3);
        end
        else if (r < 88)
        begin
            // cut short, the next frame restarts the parser
            len = $urandom_range(top, lo);
            send_frame(len, 1'b0, $urandom_range(len + 2, 1));
        end
        else if (r < 94)
        begin
            repeat ($urandom_range(4, 1)) random_read();
        end
        else
        begin
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic test_directed_frames();
        send_frame(5, 1'b0, 8);
        send_read(8'd0);
        send_read(8'd7);
        send_frame(4, 1'b0, 3);
        send_frame(255, 1'b0, 3);
        // lone header, then a pair: restart in the length phase, then bad end
        send_byte(cfg_header);
        send_frame(5, 1'b1, 8);
    endtask

    task automatic test_full_store();
        wait_idle();
        load_config(8'hFF, 8'h00, 8'd253);
        send_frame(252, 1'b0, 3);
        send_frame(253, 1'b0, 300);
        send_read(8'd255);
        send_read(8'd0);
        repeat (30) random_read();
    endtask

    task automatic test_random_traffic(input int sidle, input int ridle, input logic [7:0] hdr,
                                       input logic [7:0] endb, input logic [7:0] minl,
                                       input int count);
        int stop;
        wait_idle();
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        load_config(hdr, endb, minl);
        stop = req_count + count;
        while (req_count < stop)
            random_sequence();
    endtask

    task automatic test_backpressure();
        wait_idle();
        @(negedge clk);
        hold_cycles = 60;
        @(posedge clk);
        send_frame(30, 1'b0, 300);
        repeat (5) random_read();
    endtask

    // result side: random idling plus the long hold-off
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : check_result
        parser_status_t want;
        if (rst_n && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (parser_status_q.size() == 0)
                report_mismatch("result with nothing pending", 9'd1, 9'd0);
            else
            begin
                want = parser_status_q.pop_front();
                if (frame_done !== want.done)
                    report_mismatch("frame_done", 9'(frame_done), 9'(want.done));
                if (frame_ready !== want.ready)
                    report_mismatch("frame_ready", 9'(frame_ready), 9'(want.ready));
                if (frame_length !== want.length)
                    report_mismatch("frame_length", frame_length, want.length);
                if (error_code !== want.err)
                    report_mismatch("error_code", 9'(error_code), 9'(want.err));
                if (parser_phase !== want.phase)
                    report_mismatch("parser_phase", 9'(parser_phase), 9'(want.phase));
                if (read_data !== want.rdata)
                    report_mismatch("read_data", 9'(read_data), 9'(want.rdata));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        command    <= CMD_RX;
        rx_byte    <= '0;
        read_index <= '0;
        out_ready  <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= CFG_HEADER;
        cfg_data   <= '0;
        cfg_header  = HEADER_RESET;
        cfg_end     = END_RESET;
        cfg_min_len = MIN_LEN_RESET;
        rx_phase    = PH_HEAD1;
        hi_written  = -1;
        wr_ptr      = '0;
        len_byte    = '0;
        last_rx     = '0;
        held_valid  = 1'b0;
        held_len    = '0;
        err_count   = 0;
        req_count   = 0;
        frames_done = 0;
        len_drops   = 0;
        end_drops   = 0;
        reads_done  = 0;
        hold_cycles = 0;
        quiet_cycles  = 0;
        send_idle_pct = 21;
        recv_idle_pct = 51;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        load_config(HEADER_RESET, END_RESET, MIN_LEN_RESET);

        test_directed_frames();
        test_full_store();
        test_random_traffic(21, 51, 8'h00, 8'hFF, 8'd5, 200);
        test_random_traffic(51, 21, 8'hFF, 8'h00, 8'd9, 200);
        test_random_traffic(0, 0, 8'hFE, 8'hFA, 8'd20, 200);
        test_backpressure();
        wait_idle();

        $display("%0d requests: %0d good frames, %0d length drops, %0d end drops, %0d reads",
                 req_count, frames_done, len_drops, end_drops, reads_done);
        $display("settings: reset values, full 256-byte frame, header/end at 00 and FF, hold-off");
        if (err_count == 0 && parser_status_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
